>>> src/lrcf_pkg.sv
package lrcf_pkg;

   localparam int LED_COUNT = 12;

   localparam int IDX_W  = 4;
   localparam int NOW_W  = 32;
   localparam int LVL_W  = 8;
   localparam int MS_W   = 16;
   localparam int PROD_W = MS_W + LVL_W;

   localparam int REQ_DW = 32;
   localparam int RSP_DW = 16;

   localparam int CSR_AW = 2;
   localparam int CSR_DW = 16;

   localparam logic [LVL_W-1:0] FULL_LEVEL = 8'd255;

   localparam logic [LVL_W-1:0] RST_MIN_BRIGHT  = 8'd10;
   localparam logic [MS_W-1:0]  RST_STEP_PERIOD = 16'd300;
   localparam logic [MS_W-1:0]  RST_FADE_IN     = 16'd300;
   localparam logic [MS_W-1:0]  RST_FADE_OUT    = 16'd3300;

   typedef enum logic [CSR_AW-1:0] {
      CSR_MIN_BRIGHT  = 2'd0,
      CSR_STEP_PERIOD = 2'd1,
      CSR_FADE_IN     = 2'd2,
      CSR_FADE_OUT    = 2'd3
   } csr_index_type;

endpackage

>>> src/led_ring_chase_fader.sv
// channel | dir | data                                   | side bits
// req     | in  | tdata[31:0] now_ms                     | -
// rsp     | out | tdata[3:0] led_index, [11:4] brightness | tlast = last
// csr     | in  | csr_index selects register, csr_wdata  | csr_we
//
// each transaction on req yields LED_COUNT rsp transactions, led 0 first
// per led: one load step, one multiply, eight divider steps and one output
// step, or load plus output when the fade length is zero
// leds are worked one after another by the single shared multiply and
// restoring-divide unit
// req_tready is low until the last result has been taken; rsp stalls hold
// synchronous active-high reset restores the csr registers and the ring state
module led_ring_chase_fader (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [lrcf_pkg::REQ_DW-1:0]  req_tdata,  // [31:0] now_ms
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [lrcf_pkg::RSP_DW-1:0]  rsp_tdata,  // [3:0] led_index, [11:4] brightness
   output logic                         rsp_tlast,
   input  logic                         csr_we,
   input  logic [lrcf_pkg::CSR_AW-1:0]  csr_index,
   input  logic [lrcf_pkg::CSR_DW-1:0]  csr_wdata
);
   import lrcf_pkg::*;

   localparam logic [IDX_W-1:0] LAST_LED = IDX_W'(LED_COUNT - 1);
   localparam int STEP_W = $clog2(LVL_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LVL_W - 1);

   typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MUL, S_DIV, S_OUT} state_type;

   state_type               state_ff, state_in;
   logic [LVL_W-1:0]        min_ff, min_in;
   logic [MS_W-1:0]         step_ff, step_in;
   logic [MS_W-1:0]         fin_len_ff, fin_len_in;
   logic [MS_W-1:0]         fout_len_ff, fout_len_in;

   logic [IDX_W-1:0]        lit_ff, lit_in;
   logic [NOW_W-1:0]        last_adv_ff, last_adv_in;
   logic [NOW_W-1:0]        start_ff [LED_COUNT];
   logic [NOW_W-1:0]        start_in [LED_COUNT];
   logic [LED_COUNT-1:0]    fading_ff, fading_in;

   logic [NOW_W-1:0]        now_ff, now_in;
   logic [IDX_W-1:0]        led_ff, led_in;
   logic                    up_ff, up_in;
   logic [MS_W-1:0]         len_ff, len_in;
   logic [MS_W-1:0]         e_ff, e_in;
   logic [LVL_W-1:0]        rng_ff, rng_in;
   logic [PROD_W-1:0]       rem_ff, rem_in;
   logic [PROD_W-2:0]       dsr_ff, dsr_in;
   logic [LVL_W-1:0]        q_ff, q_in;
   logic [STEP_W-1:0]       cnt_ff, cnt_in;
   logic [LVL_W-1:0]        bright_ff, bright_in;

   logic                    req_hs;
   logic                    advance;
   logic [IDX_W-1:0]        nxt_pos;
   logic [NOW_W-1:0]        since_adv;
   logic [NOW_W-1:0]        elapsed;
   logic                    cur_up;
   logic [MS_W-1:0]         cur_len;
   logic [PROD_W:0]         trial;
   logic [LVL_W-1:0]        q_next;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {(RSP_DW - IDX_W - LVL_W)'(0), bright_ff, led_ff};
   assign rsp_tlast  = (led_ff == LAST_LED);

   assign req_hs    = req_tvalid && req_tready;
   assign since_adv = req_tdata - last_adv_ff;
   assign advance   = req_hs && (since_adv > {(NOW_W - MS_W)'(0), step_ff});
   assign nxt_pos   = (lit_ff == LAST_LED) ? '0 : lit_ff + 1'b1;

   assign cur_up  = fading_ff[led_ff];
   assign cur_len = cur_up ? fin_len_ff : fout_len_ff;
   assign elapsed = now_ff - start_ff[led_ff];

   // one restoring step: divisor is pre-shifted and slides right each cycle
   assign trial  = {1'b0, rem_ff} - {2'b0, dsr_ff};
   assign q_next = {q_ff[LVL_W-2:0], ~trial[PROD_W]};

   always_comb begin
      state_in    = state_ff;
      min_in      = min_ff;
      step_in     = step_ff;
      fin_len_in  = fin_len_ff;
      fout_len_in = fout_len_ff;
      lit_in      = lit_ff;
      last_adv_in = last_adv_ff;
      start_in    = start_ff;
      fading_in   = fading_ff;
      now_in      = now_ff;
      led_in      = led_ff;
      up_in       = up_ff;
      len_in      = len_ff;
      e_in        = e_ff;
      rng_in      = rng_ff;
      rem_in      = rem_ff;
      dsr_in      = dsr_ff;
      q_in        = q_ff;
      cnt_in      = cnt_ff;
      bright_in   = bright_ff;

      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_BRIGHT:  min_in      = csr_wdata[LVL_W-1:0];
            CSR_STEP_PERIOD: step_in     = csr_wdata[MS_W-1:0];
            CSR_FADE_IN:     fin_len_in  = csr_wdata[MS_W-1:0];
            CSR_FADE_OUT:    fout_len_in = csr_wdata[MS_W-1:0];
            default: ;
         endcase
      end

      if (advance) begin
         last_adv_in        = req_tdata;
         lit_in             = nxt_pos;
         start_in[lit_ff]   = req_tdata;
         start_in[nxt_pos]  = req_tdata;
         fading_in[lit_ff]  = 1'b0;
         fading_in[nxt_pos] = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_hs) begin
               now_in   = req_tdata;
               led_in   = '0;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            up_in  = cur_up;
            len_in = cur_len;
            rng_in = FULL_LEVEL - min_ff;
            e_in   = (elapsed > {(NOW_W - MS_W)'(0), cur_len}) ? cur_len
                                                               : elapsed[MS_W-1:0];
            if (cur_len == '0) begin
               // zero length fade counts as finished
               bright_in = cur_up ? FULL_LEVEL : min_ff;
               state_in  = S_OUT;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            rem_in   = PROD_W'(e_ff) * PROD_W'(rng_ff);
            dsr_in   = {len_ff, (LVL_W - 1)'(0)};
            q_in     = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (!trial[PROD_W]) begin
               rem_in = trial[PROD_W-1:0];
            end
            dsr_in = dsr_ff >> 1;
            q_in   = q_next;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               bright_in = up_ff ? min_ff + q_next : FULL_LEVEL - q_next;
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               if (led_ff == LAST_LED) begin
                  state_in = S_IDLE;
               end else begin
                  led_in   = led_ff + 1'b1;
                  state_in = S_LOAD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         min_ff      <= RST_MIN_BRIGHT;
         step_ff     <= RST_STEP_PERIOD;
         fin_len_ff  <= RST_FADE_IN;
         fout_len_ff <= RST_FADE_OUT;
         lit_ff      <= '0;
         last_adv_ff <= '0;
         for (int i = 0; i < LED_COUNT; i++) begin
            start_ff[i] <= '0;
         end
         fading_ff   <= LED_COUNT'(1);
         led_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         min_ff      <= min_in;
         step_ff     <= step_in;
         fin_len_ff  <= fin_len_in;
         fout_len_ff <= fout_len_in;
         lit_ff      <= lit_in;
         last_adv_ff <= last_adv_in;
         start_ff    <= start_in;
         fading_ff   <= fading_in;
         led_ff      <= led_in;
      end
      now_ff    <= now_in;
      up_ff     <= up_in;
      len_ff    <= len_in;
      e_ff      <= e_in;
      rng_ff    <= rng_in;
      rem_ff    <= rem_in;
      dsr_ff    <= dsr_in;
      q_ff      <= q_in;
      cnt_ff    <= cnt_in;
      bright_ff <= bright_in;
   end

endmodule

>>> src/lrcf_checker.sv
module lrcf_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic [lrcf_pkg::REQ_DW-1:0]  req_tdata,  // [31:0] now_ms
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [lrcf_pkg::RSP_DW-1:0]  rsp_tdata,  // [3:0] led_index, [11:4] brightness
   input logic                         rsp_tlast
);
   import lrcf_pkg::*;

   localparam logic [IDX_W-1:0] LAST_LED = IDX_W'(LED_COUNT - 1);

   logic [IDX_W-1:0] rsp_led;
   assign rsp_led = rsp_tdata[IDX_W-1:0];

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   // busy once a transaction has been taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken again before results were sent");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("req ready while results pending");

   // tlast marks exactly the highest led
   a_last_led: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_led == LAST_LED)))
      else $error("tlast does not match led index");

   // led index restarts at 0 once a transaction has been taken
   a_first_led: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid && (rsp_led == '0))
      else $error("first result after a transaction is not led 0");

endmodule

bind led_ring_chase_fader lrcf_checker u_lrcf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
